### rtl/core/srce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srce_pkg;

  typedef enum logic [3:0] {
    OP_MOV   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_STORE = 4'd3,
    OP_LOAD  = 4'd4,
    OP_CMP   = 4'd5,
    OP_JMP   = 4'd6,
    OP_JZ    = 4'd7
  } op_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [1:0]         first_reg;
    logic [1:0]         second_reg;
    logic signed [31:0] immediate;
    logic [7:0]         mem_address;
    logic [7:0]         jump_target;
  } instr_t;

  typedef struct packed {
    logic [7:0]         next_pc;
    logic               zero_flag;
    logic signed [31:0] reg_value;
    logic               bad_opcode;
  } result_t;

  // state updates of one instruction
  typedef struct packed {
    logic        rf_we;
    logic [31:0] rf_data;
    logic        mem_we;
    logic        flag_we;
    logic        flag_val;
  } wr_t;

  // reduce an 8-bit value modulo depth (depth of 16 or more)
  function automatic logic [7:0] wrap8(input logic [7:0] x, input int unsigned depth);
    logic [15:0] r;
    logic [15:0] d;
    r = {8'd0, x};
    d = 16'(depth);
    if (depth >= 256) begin
      return x;
    end
    for (int k = 3; k >= 0; k--) begin
      if (r >= (d << k)) begin
        r = r - (d << k);
      end
    end
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/srce_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module srce_alu import srce_pkg::*; #(
  parameter int PCW = 8
) (
  input  instr_t         item,
  input  logic [31:0]    ra_val,
  input  logic [31:0]    rb_val,
  input  logic [31:0]    ld_val,
  input  logic [PCW-1:0] pc_adv,
  input  logic [PCW-1:0] tgt,
  input  logic           eq_flag,
  output wr_t            wr,
  output logic [PCW-1:0] pc_next,
  output result_t        res
);

  logic bad;

  always_comb begin
    wr.rf_we    = 1'b0;
    wr.rf_data  = item.immediate;
    wr.mem_we   = 1'b0;
    wr.flag_we  = 1'b0;
    wr.flag_val = (ra_val == rb_val);
    bad         = 1'b0;
    pc_next     = pc_adv;
    case (item.cmd)
      OP_MOV: begin
        wr.rf_we = 1'b1;
      end
      OP_ADD: begin
        wr.rf_we   = 1'b1;
        wr.rf_data = ra_val + rb_val;
      end
      OP_SUB: begin
        wr.rf_we   = 1'b1;
        wr.rf_data = ra_val - rb_val;
      end
      OP_STORE: begin
        wr.mem_we = 1'b1;
      end
      OP_LOAD: begin
        wr.rf_we   = 1'b1;
        wr.rf_data = ld_val;
      end
      OP_CMP: begin
        wr.flag_we = 1'b1;
      end
      OP_JMP: begin
        pc_next = tgt;
      end
      OP_JZ: begin
        if (eq_flag) begin
          pc_next = tgt;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.next_pc    = 8'(pc_next);
    res.zero_flag  = wr.flag_we ? wr.flag_val : eq_flag;
    res.reg_value  = wr.rf_we ? wr.rf_data : ra_val;
    res.bad_opcode = bad;
  end

endmodule

`default_nettype wire

### rtl/core/small_register_cpu_execute.sv
`timescale 1ns / 1ps
`default_nettype none

// an instruction passes through the read stage and then the result register
// throughput: one instruction per cycle while the result side does not stall, set by the
// single read stage in front of the alu; reset: registers, pc and zero flag clear at once;
// the data memory is then cleared one word per cycle, every word, with instr_ready held low

module small_register_cpu_execute import srce_pkg::*; #(
  parameter int MEM_DEPTH     = 256,
  parameter int PROGRAM_DEPTH = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_ready,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int PCW = $clog2(PROGRAM_DEPTH);

  logic [31:0]    mem [MEM_DEPTH];
  logic [31:0]    rf [4];

  logic           clearing;
  logic [AW-1:0]  clr_idx;

  logic           s1_valid;
  instr_t         s1_item;
  logic [AW-1:0]  s1_addr;
  logic [PCW-1:0] s1_tgt;
  logic [31:0]    s1_ra;
  logic [31:0]    s1_rb;
  logic [31:0]    mem_q;
  logic           mem_fwd;
  logic [31:0]    mem_fwd_data;

  logic [PCW-1:0] pc;
  logic [PCW-1:0] pc_adv;
  logic [PCW-1:0] pc_next;
  logic           eq_flag;

  logic           accept;
  logic           s1_adv;
  logic           retire;
  logic           rf_we_now;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    ld_val;
  wr_t            wr;
  result_t        res;

  assign s1_adv      = !result_valid || result_ready;
  assign retire      = s1_valid && s1_adv;
  assign instr_ready = !clearing && (!s1_valid || s1_adv);
  assign accept      = instr_valid && instr_ready;
  assign rd_addr     = AW'(wrap8(instr.mem_address, MEM_DEPTH));
  assign rf_we_now   = retire && wr.rf_we;
  assign mem_we      = clearing || (retire && wr.mem_we);
  assign mem_waddr   = clearing ? clr_idx : s1_addr;
  assign mem_wdata   = clearing ? 32'd0 : s1_ra;
  assign ld_val      = mem_fwd ? mem_fwd_data : mem_q;
  assign pc_adv      = (pc == PCW'(PROGRAM_DEPTH - 1)) ? '0 : pc + PCW'(1);

  // data memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rf[i] <= '0;
      end
    end else if (rf_we_now) begin
      rf[s1_item.first_reg] <= wr.rf_data;
    end
  end

  // read stage, bypassing the register and memory writes of the instruction retiring on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item      <= instr;
      s1_addr      <= rd_addr;
      s1_tgt       <= PCW'(wrap8(instr.jump_target, PROGRAM_DEPTH));
      s1_ra        <= (rf_we_now && s1_item.first_reg == instr.first_reg) ?
                      wr.rf_data : rf[instr.first_reg];
      s1_rb        <= (rf_we_now && s1_item.first_reg == instr.second_reg) ?
                      wr.rf_data : rf[instr.second_reg];
      mem_fwd      <= retire && wr.mem_we && (s1_addr == rd_addr);
      mem_fwd_data <= s1_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (retire) begin
      s1_valid <= 1'b0;
    end
  end

  srce_alu #(
    .PCW (PCW)
  ) u_alu (
    .item    (s1_item),
    .ra_val  (s1_ra),
    .rb_val  (s1_rb),
    .ld_val  (ld_val),
    .pc_adv  (pc_adv),
    .tgt     (s1_tgt),
    .eq_flag (eq_flag),
    .wr      (wr),
    .pc_next (pc_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      eq_flag <= 1'b0;
    end else if (retire) begin
      pc <= pc_next;
      if (wr.flag_we) begin
        eq_flag <= wr.flag_val;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (retire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      result <= res;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("read stage lost its instruction under stall");

  a_flag_cmp_only: assert property (@(posedge clk) disable iff (rst)
    retire && s1_item.cmd != OP_CMP |=> $stable(eq_flag))
    else $error("zero flag changed by an instruction other than compare");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !instr_ready && !s1_valid)
    else $error("instruction in flight during memory clear");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srce_pkg::*;

  localparam logic [3:0] OP_BAD_LO = 4'd8;
  localparam logic [3:0] OP_BAD_HI = 4'd15;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    instr_t  ins;
    bit      known;
    result_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    instr_valid = 1'b0;
  logic    instr_ready;
  instr_t  instr = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // architectural state as the execute stage should see it
  bit [31:0] gpr [4];
  bit [31:0] dmem [256];
  bit [7:0]  pc_model;
  bit        zf_model;

  result_t   expected_results [$];
  stim_row_t plan [$];
  bit        next_known;
  result_t   next_want;
  bit        quiet = 1'b0;
  int        errors = 0;

  small_register_cpu_execute u_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  function automatic result_t execute_model(input instr_t ins);
    result_t res;
    bit      bad;
    bit      jumps;
    bad = 1'b0;
    jumps = (ins.cmd == OP_JMP) || (ins.cmd == OP_JZ && zf_model);
    case (ins.cmd)
      OP_MOV:   gpr[ins.first_reg] = ins.immediate;
      OP_ADD:   gpr[ins.first_reg] = gpr[ins.first_reg] + gpr[ins.second_reg];
      OP_SUB:   gpr[ins.first_reg] = gpr[ins.first_reg] - gpr[ins.second_reg];
      OP_STORE: dmem[ins.mem_address] = gpr[ins.first_reg];
      OP_LOAD:  gpr[ins.first_reg] = dmem[ins.mem_address];
      OP_CMP:   zf_model = (gpr[ins.first_reg] == gpr[ins.second_reg]);
      OP_JMP, OP_JZ: ;
      default:  bad = 1'b1;
    endcase
    pc_model = jumps ? ins.jump_target : pc_model + 8'd1;
    res.next_pc    = pc_model;
    res.zero_flag  = zf_model;
    res.reg_value  = gpr[ins.first_reg];
    res.bad_opcode = bad;
    return res;
  endfunction

  function automatic void add_row(input logic [3:0] cmd, input logic [1:0] ra,
                                  input logic [1:0] rb, input logic [31:0] imm,
                                  input logic [7:0] addr, input logic [7:0] tgt,
                                  input bit known = 1'b0, input result_t want = '0);
    stim_row_t r;
    r.ins.cmd         = cmd;
    r.ins.first_reg   = ra;
    r.ins.second_reg  = rb;
    r.ins.immediate   = imm;
    r.ins.mem_address = addr;
    r.ins.jump_target = tgt;
    r.known           = known;
    r.want            = want;
    plan.push_back(r);
  endfunction

  task automatic compare_result(input result_t want, input result_t got);
    if (got.next_pc !== want.next_pc) begin
      errors++;
      $display("%0t next_pc expected %0d got %0d", $time, want.next_pc, got.next_pc);
    end
    if (got.zero_flag !== want.zero_flag) begin
      errors++;
      $display("%0t zero_flag expected %0b got %0b", $time, want.zero_flag, got.zero_flag);
    end
    if (got.reg_value !== want.reg_value) begin
      errors++;
      $display("%0t reg_value expected %h got %h", $time, want.reg_value, got.reg_value);
    end
    if (got.bad_opcode !== want.bad_opcode) begin
      errors++;
      $display("%0t bad_opcode expected %0b got %0b", $time, want.bad_opcode,
               got.bad_opcode);
    end
  endtask

  task automatic transfer_instr(input instr_t x, input bit known, input result_t want);
    while (!quiet && $urandom_range(99) < 6) begin
      instr_valid <= 1'b0;
      @(negedge clk);
    end
    instr       <= x;
    instr_valid <= 1'b1;
    next_known  = known;
    next_want   = want;
    do @(posedge clk); while (!instr_ready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    result_ready <= quiet || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    result_t guess;
    if (!rst) begin
      if (instr_valid && instr_ready) begin
        guess = execute_model(instr);
        expected_results.push_back(next_known ? next_want : guess);
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result expected none got %h", $time, result);
        end else begin
          compare_result(expected_results.pop_front(), result);
        end
      end
    end
  end

  initial begin
    instr_t ins;
    // known outcomes straight after reset
    add_row(OP_BAD_HI, 2'd3, 2'd3, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1,
            '{8'd1, 1'b0, 32'd0, 1'b1});
    add_row(OP_LOAD, 2'd1, 2'd0, 32'd0, 8'd255, 8'd0, 1'b1, '{8'd2, 1'b0, 32'd0, 1'b0});
    add_row(OP_MOV, 2'd0, 2'd0, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b1,
            '{8'd3, 1'b0, 32'h7FFF_FFFF, 1'b0});
    add_row(OP_MOV, 2'd1, 2'd0, 32'h8000_0000, 8'd0, 8'd0, 1'b1,
            '{8'd4, 1'b0, 32'h8000_0000, 1'b0});
    add_row(OP_MOV, 2'd2, 2'd0, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b1,
            '{8'd5, 1'b0, 32'hFFFF_FFFF, 1'b0});
    // wrapping arithmetic
    add_row(OP_ADD, 2'd2, 2'd2, 32'd0, 8'd0, 8'd0);
    add_row(OP_ADD, 2'd0, 2'd1, 32'd0, 8'd0, 8'd0);
    add_row(OP_SUB, 2'd3, 2'd1, 32'd0, 8'd0, 8'd0);
    add_row(OP_SUB, 2'd1, 2'd2, 32'd0, 8'd0, 8'd0);
    // memory at both ends
    add_row(OP_STORE, 2'd0, 2'd0, 32'd0, 8'd255, 8'd0);
    add_row(OP_STORE, 2'd3, 2'd0, 32'd0, 8'd0, 8'd0);
    add_row(OP_LOAD, 2'd2, 2'd0, 32'd0, 8'd255, 8'd0);
    add_row(OP_LOAD, 2'd1, 2'd0, 32'd0, 8'd0, 8'd0);
    // compare and branches, pc wrap
    add_row(OP_CMP, 2'd0, 2'd2, 32'd0, 8'd0, 8'd0);
    add_row(OP_JZ, 2'd0, 2'd0, 32'd0, 8'd0, 8'd255);
    add_row(OP_MOV, 2'd3, 2'd0, 32'd0, 8'd0, 8'd0);
    add_row(OP_CMP, 2'd0, 2'd3, 32'd0, 8'd0, 8'd0);
    add_row(OP_JZ, 2'd0, 2'd0, 32'd0, 8'd0, 8'd128);
    add_row(OP_CMP, 2'd1, 2'd1, 32'd0, 8'd0, 8'd0);
    add_row(OP_JMP, 2'd2, 2'd0, 32'd0, 8'd0, 8'd0);
    add_row(OP_JMP, 2'd1, 2'd0, 32'd0, 8'd0, 8'd255);
    // unknown opcode leaves the flag set
    add_row(OP_BAD_LO, 2'd0, 2'd0, 32'd0, 8'd0, 8'd0);
    add_row(OP_JZ, 2'd3, 2'd0, 32'd0, 8'd0, 8'd0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) transfer_instr(plan[i].ins, plan[i].known, plan[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 600) && (i < 1000);
      if ($urandom_range(99) < 8) ins.cmd = 4'($urandom_range(15, 8));
      else ins.cmd = 4'($urandom_range(7, 0));
      ins.first_reg  = 2'($urandom_range(3));
      ins.second_reg = ($urandom_range(3) == 0) ? ins.first_reg : 2'($urandom_range(3));
      case ($urandom_range(7))
        0:       ins.immediate = 32'h8000_0000;
        1:       ins.immediate = 32'h7FFF_FFFF;
        2, 3:    ins.immediate = $urandom_range(3);
        default: ins.immediate = $urandom;
      endcase
      // a small pool of addresses so loads mostly find stored data
      case ($urandom_range(3))
        0:       ins.mem_address = 8'($urandom_range(255));
        1:       ins.mem_address = 8'($urandom_range(255, 248));
        default: ins.mem_address = 8'($urandom_range(7));
      endcase
      ins.jump_target = 8'($urandom_range(255));
      transfer_instr(ins, 1'b0, '0);
    end
    instr_valid <= 1'b0;
    quiet = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/core/srce_pkg.sv
rtl/core/srce_alu.sv
rtl/core/small_register_cpu_execute.sv
tb/testbench.sv
